// ===== design/cps_pkg.sv =====
// Shared constants for the chirp ping synthesizer: register map and fixed-point coefficients.
package cps_pkg;

    // Configuration port geometry.
    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 32;

    // Register indexes (byte address is four times the index).
    localparam logic [2:0] REG_START_INC  = 3'd0;
    localparam logic [2:0] REG_INC_STEP   = 3'd1;
    localparam logic [2:0] REG_TOTAL      = 3'd2;
    localparam logic [2:0] REG_AMP_GAIN   = 3'd3;
    localparam logic [2:0] REG_NOISE_GAIN = 3'd4;
    localparam logic [2:0] REG_NOISE_SEED = 3'd5;

    // Register reset values.
    localparam logic [23:0] TOTAL_RESET      = 24'd441;
    localparam logic [15:0] AMP_GAIN_RESET   = 16'd32768;
    localparam logic [15:0] NOISE_SEED_RESET = 16'd44257;

    // Quarter-wave sine polynomial coefficients, Q30.
    localparam logic [31:0] SINE_C1 = 32'd1686557207;
    localparam logic [31:0] SINE_C2 = 32'd690662094;
    localparam logic [31:0] SINE_C3 = 32'd78071983;
    localparam logic [15:0] SINE_MAX = 16'd32767;

    // Second harmonic level, 0.18 in Q15.
    localparam logic [31:0] HARM_GAIN = 32'd5898;

    // Envelope recurrences, Q23 state and Q24 per-sample factors.
    localparam logic [23:0] ONE_Q23       = 24'h80_0000;
    localparam logic [31:0] ATTACK_FACTOR = 32'd16766350;
    localparam logic [31:0] DECAY_FACTOR  = 32'd16775753;

    // Output scaling and clamp bound.
    localparam logic [31:0] OUT_SCALE = 32'd32767;
    localparam logic [30:0] V_LIMIT   = 31'h4000_0000;

    // Noise generator.
    localparam logic [15:0] LFSR_TAPS    = 16'hB400;
    localparam logic [15:0] LFSR_DEFAULT = 16'hACE1;

endpackage

// ===== design/chirp_ping_synthesizer.sv =====
// Top level of the chirp ping synthesizer: sample sequencer, shared multiplier and register file.
//
//  Channel   Direction  Signals                        Carries
//  s_*       in         s_tvalid s_tready s_tdata[7:0]  one sample tick: start_req, abort
//  m_*       out        m_tvalid m_tready m_tdata[15:0] one audio sample, m_tlast on the
//                       m_tlast                         final sample of a ping
//  APB       in/out     psel penable pwrite paddr ...   six configuration registers
//
// A tick that produces a sample passes through ST_SWEEP, ST_WSET, a multiply and a post-processing
// state for each product, and ST_OUT before the sample is offered on the output; the next tick is
// accepted once the sequencer is back in idle. The single 32x32 multiplier is used by the sequencer
// sixteen times per sample, with a multiply step and a post-processing step for each product.
// Ticks that produce nothing (idle or abort) finish in the accepting cycle.
// rst_n clears the sequencer, the ping state and the registers to their reset values.
// A stalled output holds its sample; the next tick may still be accepted and worked on,
// and the sequencer waits at its final step until the output register is free.
module chirp_ping_synthesizer #(
    parameter int SINE_TABLE_BITS = 10,
    parameter int PHASE_WIDTH     = 32,
    parameter int COUNT_WIDTH     = 24
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // Input stream.
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,   // [0] start_req, [1] abort
    // Output stream.
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [15:0]                    m_tdata,   // [15:0] sample (signed)
    output logic                           m_tlast,
    // Configuration port.
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [cps_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [cps_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [cps_pkg::CFG_DATA_W-1:0] prdata,
    output logic                           pready
);

    import cps_pkg::*;

    localparam int IDX_W   = SINE_TABLE_BITS + 2;
    localparam int KK_W    = SINE_TABLE_BITS + 1;
    localparam int X_SHIFT = 16 - SINE_TABLE_BITS;
    localparam int LIM_W   = (COUNT_WIDTH > 24) ? COUNT_WIDTH : 24;
    localparam logic [KK_W-1:0] QUARTER = KK_W'(1) << SINE_TABLE_BITS;

    // One state per multiply and one per post-processing step.
    typedef enum logic [4:0] {
        ST_IDLE, ST_SWEEP, ST_WSET,
        ST_M_X2, ST_P_X2, ST_M_T, ST_P_T, ST_M_U, ST_P_U, ST_M_S, ST_P_S,
        ST_M_H, ST_P_H, ST_M_N, ST_P_N, ST_M_E, ST_P_E, ST_M_G, ST_P_G,
        ST_M_V, ST_P_V, ST_M_M, ST_P_M, ST_M_R, ST_P_R, ST_M_D, ST_P_D,
        ST_OUT
    } state_t;

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    logic [30:0] start_inc_reg;
    logic [31:0] inc_step_reg;
    logic [23:0] total_reg;
    logic [15:0] amp_gain_reg;
    logic [15:0] noise_gain_reg;
    logic [15:0] noise_seed_reg;

    logic       cfg_write;
    logic [2:0] cfg_index;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_index = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_inc_reg  <= '0;
            inc_step_reg   <= '0;
            total_reg      <= TOTAL_RESET;
            amp_gain_reg   <= AMP_GAIN_RESET;
            noise_gain_reg <= '0;
            noise_seed_reg <= NOISE_SEED_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_START_INC:  start_inc_reg  <= pwdata[30:0];
                REG_INC_STEP:   inc_step_reg   <= pwdata;
                REG_TOTAL:      total_reg      <= pwdata[23:0];
                REG_AMP_GAIN:   amp_gain_reg   <= pwdata[15:0];
                REG_NOISE_GAIN: noise_gain_reg <= pwdata[15:0];
                REG_NOISE_SEED: noise_seed_reg <= pwdata[15:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_index)
            REG_START_INC:  prdata = {1'b0, start_inc_reg};
            REG_INC_STEP:   prdata = inc_step_reg;
            REG_TOTAL:      prdata = {8'h00, total_reg};
            REG_AMP_GAIN:   prdata = {16'h0000, amp_gain_reg};
            REG_NOISE_GAIN: prdata = {16'h0000, noise_gain_reg};
            REG_NOISE_SEED: prdata = {16'h0000, noise_seed_reg};
            default:        prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Ping state, sequencer and datapath registers.
    // ------------------------------------------------------------------
    state_t                   state_reg;
    logic                     active_reg;
    logic [COUNT_WIDTH-1:0]   count_reg;
    logic [PHASE_WIDTH-1:0]   phase_reg;
    logic signed [47:0]       sweep_reg;
    logic [23:0]              resid_reg;
    logic [23:0]              decay_reg;
    logic [15:0]              lfsr_reg;

    logic                     pass_reg;     // 0 while building the fundamental, 1 for the harmonic
    logic                     neg_reg;      // sign of the current wave point or of the product v
    logic [16:0]              x_reg;        // wave abscissa, Q16
    logic [16:0]              x2_reg;       // x squared, Q16
    logic [30:0]              poly_reg;     // polynomial partial term, Q30
    logic signed [15:0]       s2_reg;       // second harmonic wave value
    logic signed [17:0]       sig_reg;      // running sum of the signal terms
    logic [23:0]              env_reg;      // envelope, Q23
    logic [15:0]              gain_reg;     // amplitude times envelope, Q15
    logic [30:0]              mag_reg;      // clamped magnitude of v, Q30
    logic [15:0]              result_reg;
    logic                     result_last_reg;
    logic signed [63:0]       prod_reg;

    logic                     m_tvalid_reg;
    logic [15:0]              m_tdata_reg;
    logic                     m_tlast_reg;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    // Sweep: the increment used this tick, and the saturated next sweep value.
    logic [31:0]              inc_cur;
    logic signed [48:0]       sweep_sum;
    logic signed [47:0]       sweep_next;
    logic [PHASE_WIDTH-1:0]   phase_next;

    always_comb
    begin
        if (sweep_reg[47] || (sweep_reg == '0))
            inc_cur = {1'b0, start_inc_reg};
        else
            inc_cur = sweep_reg[47:16];
        sweep_sum = {sweep_reg[47], sweep_reg} + {{17{inc_step_reg[31]}}, inc_step_reg};
        if (sweep_sum[48] != sweep_sum[47])
            sweep_next = sweep_sum[48] ? {1'b1, 47'h0} : {1'b0, {47{1'b1}}};
        else
            sweep_next = sweep_sum[47:0];
        phase_next = phase_reg + inc_cur[31 -: PHASE_WIDTH];
    end

    // Wave point selection: top phase bits, doubled for the harmonic, folded into a quarter.
    logic [IDX_W-1:0] idx_base;
    logic [IDX_W-1:0] idx_sel;
    logic [KK_W-1:0]  kk;

    always_comb
    begin
        idx_base = phase_reg[PHASE_WIDTH-1 -: IDX_W];
        idx_sel  = pass_reg ? {idx_base[IDX_W-2:0], 1'b0} : idx_base;
        if (idx_sel[SINE_TABLE_BITS])
            kk = QUARTER - KK_W'(idx_sel[SINE_TABLE_BITS-1:0]);
        else
            kk = KK_W'(idx_sel[SINE_TABLE_BITS-1:0]);
    end

    // The shared multiplier; its operands are chosen by the sequencer step.
    logic signed [31:0] mult_a;
    logic signed [31:0] mult_b;
    logic signed [63:0] prod_next;

    always_comb
    begin
        case (state_reg)
            ST_M_X2:
            begin
                mult_a = $signed(32'(x_reg));
                mult_b = $signed(32'(x_reg));
            end
            ST_M_T:
            begin
                mult_a = $signed(SINE_C3);
                mult_b = $signed(32'(x2_reg));
            end
            ST_M_U:
            begin
                mult_a = $signed(32'(poly_reg));
                mult_b = $signed(32'(x2_reg));
            end
            ST_M_S:
            begin
                mult_a = $signed(32'(poly_reg));
                mult_b = $signed(32'(x_reg));
            end
            ST_M_H:
            begin
                mult_a = $signed(HARM_GAIN);
                mult_b = 32'(s2_reg);
            end
            ST_M_N:
            begin
                // lfsr - 32768 is the LFSR word with its top bit inverted, read as signed.
                mult_a = $signed(32'(noise_gain_reg));
                mult_b = 32'($signed({~lfsr_reg[15], lfsr_reg[14:0]}));
            end
            ST_M_E:
            begin
                mult_a = $signed(32'(ONE_Q23 - resid_reg));
                mult_b = $signed(32'(decay_reg));
            end
            ST_M_G:
            begin
                mult_a = $signed(32'(amp_gain_reg));
                mult_b = $signed(32'(env_reg));
            end
            ST_M_V:
            begin
                mult_a = $signed(32'(gain_reg));
                mult_b = 32'(sig_reg);
            end
            ST_M_M:
            begin
                mult_a = $signed(32'(mag_reg));
                mult_b = $signed(OUT_SCALE);
            end
            ST_M_R:
            begin
                mult_a = $signed(32'(resid_reg));
                mult_b = $signed(ATTACK_FACTOR);
            end
            ST_M_D:
            begin
                mult_a = $signed(32'(decay_reg));
                mult_b = $signed(DECAY_FACTOR);
            end
            default:
            begin
                mult_a = '0;
                mult_b = '0;
            end
        endcase
    end

    assign prod_next = mult_a * mult_b;

    // Post-processing of the registered product.
    logic [63:0]        poly_diff;
    logic [32:0]        sine_rnd;
    logic [15:0]        sine_mag;
    logic signed [15:0] sine_val;
    logic [63:0]        v_abs;
    logic [30:0]        mag_next;
    logic [15:0]        samp_mag;
    logic [COUNT_WIDTH-1:0] count_next;
    logic [LIM_W-1:0]   limit;
    logic               last_next;
    logic [15:0]        lfsr_next;

    always_comb
    begin
        // Polynomial steps: coefficient minus the product scaled down by 2^16.
        poly_diff = 64'((state_reg == ST_P_T) ? SINE_C2 : SINE_C1)
                    - 64'(prod_reg >>> 16);
        // Final sine step: scale to Q15 with rounding and clamp at full scale.
        sine_rnd = (33'(prod_reg[47:16]) + 33'd16384) >> 15;
        sine_mag = (sine_rnd > 33'(SINE_MAX)) ? SINE_MAX : sine_rnd[15:0];
        sine_val = neg_reg ? -$signed(sine_mag) : $signed(sine_mag);
        // Gain times signal, clamped to plus or minus one in Q30.
        v_abs    = prod_reg[63] ? 64'(-prod_reg) : 64'(prod_reg);
        mag_next = (v_abs > 64'(V_LIMIT)) ? V_LIMIT : v_abs[30:0];
        samp_mag = prod_reg[45:30];
        // Length bookkeeping; a zero length behaves as one.
        count_next = count_reg + COUNT_WIDTH'(1);
        if (LIM_W'(total_reg) > LIM_W'({COUNT_WIDTH{1'b1}}))
            limit = LIM_W'({COUNT_WIDTH{1'b1}});
        else
            limit = LIM_W'(total_reg);
        last_next = (LIM_W'(count_next) >= limit);
        lfsr_next = lfsr_reg[0] ? ((lfsr_reg >> 1) ^ LFSR_TAPS) : (lfsr_reg >> 1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            active_reg      <= 1'b0;
            count_reg       <= '0;
            phase_reg       <= '0;
            sweep_reg       <= '0;
            resid_reg       <= '0;
            decay_reg       <= '0;
            lfsr_reg        <= LFSR_DEFAULT;
            pass_reg        <= 1'b0;
            neg_reg         <= 1'b0;
            x_reg           <= '0;
            x2_reg          <= '0;
            poly_reg        <= '0;
            s2_reg          <= '0;
            sig_reg         <= '0;
            env_reg         <= '0;
            gain_reg        <= '0;
            mag_reg         <= '0;
            result_reg      <= '0;
            result_last_reg <= 1'b0;
            prod_reg        <= '0;
            m_tvalid_reg    <= 1'b0;
            m_tdata_reg     <= '0;
            m_tlast_reg     <= 1'b0;
        end
        else
        begin
            prod_reg <= prod_next;
            // In ST_OUT the hand-off below decides the output valid flag.
            if (m_tvalid_reg && m_tready && (state_reg != ST_OUT))
                m_tvalid_reg <= 1'b0;

            case (state_reg)
                ST_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        if (s_tdata[0])
                        begin
                            // Start (wins over abort) re-arms the ping from the top.
                            active_reg <= 1'b1;
                            count_reg  <= '0;
                            phase_reg  <= '0;
                            sweep_reg  <= $signed(48'({start_inc_reg, 16'h0000}));
                            resid_reg  <= ONE_Q23;
                            decay_reg  <= ONE_Q23;
                            lfsr_reg   <= (noise_seed_reg != '0) ? noise_seed_reg
                                                                : LFSR_DEFAULT;
                            state_reg  <= ST_SWEEP;
                        end
                        else if (s_tdata[1] && active_reg)
                            active_reg <= 1'b0;
                        else if (active_reg)
                            state_reg <= ST_SWEEP;
                    end
                end
                ST_SWEEP:
                begin
                    sweep_reg <= sweep_next;
                    phase_reg <= phase_next;
                    pass_reg  <= 1'b0;
                    state_reg <= ST_WSET;
                end
                ST_WSET:
                begin
                    x_reg     <= 17'(kk) << X_SHIFT;
                    neg_reg   <= idx_sel[SINE_TABLE_BITS+1];
                    state_reg <= ST_M_X2;
                end
                ST_M_X2: state_reg <= ST_P_X2;
                ST_P_X2:
                begin
                    x2_reg    <= prod_reg[32:16];
                    state_reg <= ST_M_T;
                end
                ST_M_T: state_reg <= ST_P_T;
                ST_P_T:
                begin
                    poly_reg  <= poly_diff[30:0];
                    state_reg <= ST_M_U;
                end
                ST_M_U: state_reg <= ST_P_U;
                ST_P_U:
                begin
                    poly_reg  <= poly_diff[30:0];
                    state_reg <= ST_M_S;
                end
                ST_M_S: state_reg <= ST_P_S;
                ST_P_S:
                begin
                    if (!pass_reg)
                    begin
                        sig_reg   <= 18'(sine_val);
                        pass_reg  <= 1'b1;
                        state_reg <= ST_WSET;
                    end
                    else
                    begin
                        s2_reg    <= sine_val;
                        state_reg <= ST_M_H;
                    end
                end
                ST_M_H: state_reg <= ST_P_H;
                ST_P_H:
                begin
                    sig_reg   <= sig_reg + 18'(prod_reg >>> 15);
                    state_reg <= ST_M_N;
                end
                ST_M_N: state_reg <= ST_P_N;
                ST_P_N:
                begin
                    sig_reg   <= sig_reg + 18'(prod_reg >>> 15);
                    state_reg <= ST_M_E;
                end
                ST_M_E: state_reg <= ST_P_E;
                ST_P_E:
                begin
                    env_reg   <= prod_reg[46:23];
                    state_reg <= ST_M_G;
                end
                ST_M_G: state_reg <= ST_P_G;
                ST_P_G:
                begin
                    gain_reg  <= prod_reg[38:23];
                    state_reg <= ST_M_V;
                end
                ST_M_V: state_reg <= ST_P_V;
                ST_P_V:
                begin
                    mag_reg   <= mag_next;
                    neg_reg   <= prod_reg[63];
                    state_reg <= ST_M_M;
                end
                ST_M_M: state_reg <= ST_P_M;
                ST_P_M:
                begin
                    result_reg <= neg_reg ? 16'(-$signed(samp_mag)) : samp_mag;
                    state_reg  <= ST_M_R;
                end
                ST_M_R: state_reg <= ST_P_R;
                ST_P_R:
                begin
                    resid_reg <= 24'((prod_reg + 64'(ONE_Q23)) >>> 24);
                    state_reg <= ST_M_D;
                end
                ST_M_D: state_reg <= ST_P_D;
                ST_P_D:
                begin
                    decay_reg       <= 24'((prod_reg + 64'(ONE_Q23)) >>> 24);
                    lfsr_reg        <= lfsr_next;
                    count_reg       <= count_next;
                    result_last_reg <= last_next;
                    if (last_next)
                        active_reg <= 1'b0;
                    state_reg <= ST_OUT;
                end
                ST_OUT:
                begin
                    // Hand the sample to the output register once it is free.
                    if (!m_tvalid_reg || m_tready)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= result_reg;
                        m_tlast_reg  <= result_last_reg;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------

    // Both envelope recurrences decay from one and never exceed it.
    assert property (@(posedge clk) disable iff (!rst_n)
        (resid_reg <= ONE_Q23) && (decay_reg <= ONE_Q23))
        else $error("envelope term above unity");

    // The clamped magnitude of the gain-signal product stays within one in Q30.
    assert property (@(posedge clk) disable iff (!rst_n)
        mag_reg <= V_LIMIT)
        else $error("clamped magnitude out of range");

    // When the final sample of a ping is offered, the ping is already over.
    assert property (@(posedge clk) disable iff (!rst_n)
        ($rose(m_tvalid_reg) && m_tlast_reg) |-> !active_reg)
        else $error("ping still active after its last sample");

    // The sequencer only leaves idle for a running or freshly started ping.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SWEEP) |-> active_reg)
        else $error("sample computed without an active ping");

endmodule
